// ----- hw/rtl/avcnal_pkg.sv -----
package avcnal_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_UNIT_END = 2'd2,
        KIND_ZERO_LEN = 2'd3
    } t_kind;

    // Unit types that carry an extension header
    localparam logic [4:0] TYPE_PREFIX_EXT = 5'd14;
    localparam logic [4:0] TYPE_SLICE_EXT  = 5'd20;
    localparam logic [4:0] TYPE_DEPTH_EXT  = 5'd21;

    // Emulation prevention byte
    localparam logic [7:0] EPB_BYTE = 8'h03;

    // Record prefix length before the sequence set count byte
    localparam logic [2:0] PREFIX_LEN = 3'd5;

    // Result queue between parser and output stage
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic        forbidden_bit;
        logic [1:0]  ref_idc;
        logic [4:0]  unit_type;
        logic        ext_flag;
        logic        set_kind;
        logic [7:0]  unit_index;
        logic        last;
    } t_result;

endpackage

// ----- hw/rtl/avcnal_front.sv -----
module avcnal_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    output logic                 o_push,
    output avcnal_pkg::t_result  o_result
);

    typedef enum logic [3:0] {
        PH_PREFIX    = 4'd0,
        PH_LEN_HI    = 4'd1,
        PH_LEN_LO    = 4'd2,
        PH_HEADER    = 4'd3,
        PH_FLAG      = 4'd4,
        PH_SKIP      = 4'd5,
        PH_PAYLOAD   = 4'd6,
        PH_PPS_COUNT = 4'd7,
        PH_DONE      = 4'd8
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_units, n_units;
    logic [15:0] r_bytes, n_bytes;
    logic [1:0]  r_skip, n_skip;
    logic [1:0]  r_zrun, n_zrun;
    logic [4:0]  r_type, n_type;
    logic        r_list, n_list;
    logic [7:0]  r_idx, n_idx;
    logic        r_forb, n_forb;
    logic [1:0]  r_ref, n_ref;
    logic        r_ext, n_ext;

    logic        push;
    logic        hdr_valid;
    logic        last;
    logic        end_unit;

    avcnal_pkg::t_kind kind;
    logic [7:0]  pay;
    logic [15:0] len;
    logic [15:0] bytes_dec;
    logic [7:0]  units_dec;
    logic        ext_type;

    // Decrement helpers shared by the unit byte phases
    assign bytes_dec = r_bytes - 16'd1;
    assign units_dec = (r_units != 8'd0) ? r_units - 8'd1 : r_units;
    assign len       = {r_bytes[15:8], i_byte};
    assign ext_type  = (i_byte[4:0] == avcnal_pkg::TYPE_PREFIX_EXT) ||
                       (i_byte[4:0] == avcnal_pkg::TYPE_SLICE_EXT)  ||
                       (i_byte[4:0] == avcnal_pkg::TYPE_DEPTH_EXT);

    // Parse one byte and classify it
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_units   = r_units;
        n_bytes   = r_bytes;
        n_skip    = r_skip;
        n_zrun    = r_zrun;
        n_type    = r_type;
        n_list    = r_list;
        n_idx     = r_idx;
        n_forb    = r_forb;
        n_ref     = r_ref;
        n_ext     = r_ext;
        push      = 1'b0;
        hdr_valid = 1'b1;
        last      = 1'b0;
        end_unit  = 1'b0;
        kind      = avcnal_pkg::KIND_HEADER;
        pay       = 8'd0;

        unique case (r_phase)
            PH_PREFIX: begin
                if (r_pos < avcnal_pkg::PREFIX_LEN) begin
                    n_pos = r_pos + 3'd1;
                end else begin
                    n_units = {3'd0, i_byte[4:0]};
                    n_list  = 1'b0;
                    n_idx   = 8'd0;
                    n_phase = (i_byte[4:0] != 5'd0) ? PH_LEN_HI : PH_PPS_COUNT;
                end
            end
            PH_PPS_COUNT: begin
                n_units = i_byte;
                n_list  = 1'b1;
                n_idx   = 8'd0;
                n_phase = (i_byte != 8'd0) ? PH_LEN_HI : PH_DONE;
            end
            PH_LEN_HI: begin
                n_bytes = {i_byte, 8'd0};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_bytes = len;
                if (len == 16'd0) begin
                    push      = 1'b1;
                    kind      = avcnal_pkg::KIND_ZERO_LEN;
                    hdr_valid = 1'b0;
                    last      = 1'b1;
                    end_unit  = 1'b1;
                end else begin
                    n_zrun  = 2'd0;
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                n_forb  = i_byte[7];
                n_ref   = i_byte[6:5];
                n_type  = i_byte[4:0];
                n_ext   = 1'b0;
                n_bytes = bytes_dec;
                last    = (bytes_dec == 16'd0);
                if (ext_type && !last) begin
                    n_phase = PH_FLAG;
                end else begin
                    push     = 1'b1;
                    kind     = avcnal_pkg::KIND_HEADER;
                    end_unit = last;
                    if (!last) begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_FLAG: begin
                n_ext    = i_byte[7];
                n_bytes  = bytes_dec;
                last     = (bytes_dec == 16'd0);
                n_skip   = ((r_type == avcnal_pkg::TYPE_DEPTH_EXT) && i_byte[7]) ? 2'd1 : 2'd2;
                push     = 1'b1;
                kind     = avcnal_pkg::KIND_HEADER;
                end_unit = last;
                if (!last) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_bytes = bytes_dec;
                if (r_skip != 2'd0) begin
                    n_skip = r_skip - 2'd1;
                end
                if (bytes_dec == 16'd0) begin
                    push     = 1'b1;
                    kind     = avcnal_pkg::KIND_UNIT_END;
                    last     = 1'b1;
                    end_unit = 1'b1;
                end else if (r_skip <= 2'd1) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_bytes = bytes_dec;
                last    = (bytes_dec == 16'd0);
                if ((r_zrun == 2'd2) && (i_byte == avcnal_pkg::EPB_BYTE)) begin
                    // Drop the emulation prevention byte
                    n_zrun = 2'd0;
                    if (last) begin
                        push     = 1'b1;
                        kind     = avcnal_pkg::KIND_UNIT_END;
                        end_unit = 1'b1;
                    end
                end else begin
                    if (i_byte == 8'd0) begin
                        n_zrun = (r_zrun == 2'd2) ? 2'd2 : r_zrun + 2'd1;
                    end else begin
                        n_zrun = 2'd0;
                    end
                    push     = 1'b1;
                    kind     = avcnal_pkg::KIND_PAYLOAD;
                    pay      = i_byte;
                    end_unit = last;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // Close the unit and pick the next list position
        if (end_unit) begin
            n_units = units_dec;
            n_idx   = r_idx + 8'd1;
            if (units_dec != 8'd0) begin
                n_phase = PH_LEN_HI;
            end else if (!r_list) begin
                n_phase = PH_PPS_COUNT;
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    // Assemble the result
    always_comb begin
        o_result.kind          = kind;
        o_result.payload_byte  = pay;
        o_result.forbidden_bit = hdr_valid ? n_forb : 1'b0;
        o_result.ref_idc       = hdr_valid ? n_ref  : 2'd0;
        o_result.unit_type     = hdr_valid ? n_type : 5'd0;
        o_result.ext_flag      = hdr_valid ? n_ext  : 1'b0;
        o_result.set_kind      = r_list;
        o_result.unit_index    = r_idx;
        o_result.last          = last;
    end

    assign o_push = i_accept && push;

    // Advance parser state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_pos   <= 3'd0;
            r_units <= 8'd0;
            r_bytes <= 16'd0;
            r_skip  <= 2'd0;
            r_zrun  <= 2'd0;
            r_type  <= 5'd0;
            r_list  <= 1'b0;
            r_idx   <= 8'd0;
            r_forb  <= 1'b0;
            r_ref   <= 2'd0;
            r_ext   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_units <= n_units;
            r_bytes <= n_bytes;
            r_skip  <= n_skip;
            r_zrun  <= n_zrun;
            r_type  <= n_type;
            r_list  <= n_list;
            r_idx   <= n_idx;
            r_forb  <= n_forb;
            r_ref   <= n_ref;
            r_ext   <= n_ext;
        end
    end

endmodule

// ----- hw/rtl/avcnal_queue.sv -----
module avcnal_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  avcnal_pkg::t_result  i_item,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_avail,
    output avcnal_pkg::t_result  o_item
);

    localparam logic [avcnal_pkg::QAW:0] FULL_COUNT = (avcnal_pkg::QAW + 1)'(avcnal_pkg::QDEPTH);

    avcnal_pkg::t_result           r_mem [avcnal_pkg::QDEPTH];
    logic [avcnal_pkg::QAW-1:0]    r_wr_ptr;
    logic [avcnal_pkg::QAW-1:0]    r_rd_ptr;
    logic [avcnal_pkg::QAW:0]      r_count, n_count;

    assign o_ready = (r_count != FULL_COUNT);
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ----- hw/rtl/avcnal_back.sv -----
module avcnal_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  avcnal_pkg::t_result  i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output avcnal_pkg::t_result  o_item
);

    logic                r_valid;
    avcnal_pkg::t_result r_item;

    // Load the output register when it is empty or being drained
    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_avail;
        end
    end

    // Hold payload until transfer
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- hw/rtl/avc_nal_unit_deframer.sv -----
// A result enters the queue when its byte is transferred, then moves on into the output register.
// One byte per cycle unless the queue is full; every input byte gives at most one result.
// A four-entry result queue lets the parser run on while the output stalls;
// tready drops only while all four queue entries hold results.
// Reset (synchronous, active low) returns the parser to the start of the record
// and empties the queue and the output register.
module avc_nal_unit_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] payload_byte, [8] forbidden_bit, [10:9] ref_idc,
                                     // [15:11] unit_type, [16] ext_flag, [24:17] unit_index,
                                     // [31:25] zero
    output logic [2:0]  o_m_tuser,   // [1:0] kind, [2] set_kind
    output logic        o_m_tlast    // last
);

    logic                q_ready;
    logic                s_accept;
    logic                push;
    avcnal_pkg::t_result front_res;
    logic                q_avail;
    logic                pop;
    avcnal_pkg::t_result q_item;
    avcnal_pkg::t_result out_item;

    assign o_s_tready = q_ready;
    assign s_accept   = i_s_tvalid && q_ready;

    avcnal_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_tdata),
        .o_push   (push),
        .o_result (front_res)
    );

    avcnal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_res),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    avcnal_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_item  (out_item)
    );

    // Pack the result fields onto the master side
    assign o_m_tdata = {7'd0, out_item.unit_index, out_item.ext_flag, out_item.unit_type,
                        out_item.ref_idc, out_item.forbidden_bit, out_item.payload_byte};
    assign o_m_tuser = {out_item.set_kind, out_item.kind};
    assign o_m_tlast = out_item.last;

endmodule
